@@ sv/grid_cell_track_associator_defines.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; included by the checker.
`ifndef GRID_CELL_TRACK_ASSOCIATOR_DEFINES_SVH
`define GRID_CELL_TRACK_ASSOCIATOR_DEFINES_SVH
// implication checked on every clock, idle during reset
`define GCTA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define GCTA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ sv/gcta_pkg.sv @@
// Shared constants, types and helpers for the grid cell track associator.
// Depends on nothing.
`default_nettype none
package gcta_pkg;
    localparam int MAX_TRACKS     = 16;
    localparam int MAX_DETECTIONS = 16;
    localparam int TW = $clog2(MAX_TRACKS);
    localparam int DW = $clog2(MAX_DETECTIONS);
    localparam int TCW = $clog2(MAX_TRACKS + 1);
    localparam int DCW = $clog2(MAX_DETECTIONS + 1);
    localparam logic [6:0] CAP_RESET = 7'd100;
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_END = 1'b1;

    // datapath commands
    typedef struct packed {
        logic add_scan;     // compare incoming cell against pending entry
        logic add_push;     // append incoming cell
        logic clr_frame;    // clear per-frame flags
        logic load_trk;     // latch track i cell
        logic near_step;    // nearest check: track i vs detection j
        logic near_init;    // start nearest check of track i
        logic best_step;    // fold candidate i into best for detection k
        logic best_init;
        logic assign_k;     // commit detection k
        logic new_k;        // start new track for detection k (if free)
        logic age_i;        // age track i, compact
        logic age_init;
        logic emit_i;       // load output from track i
        logic emit_empty;
        logic pend_clr;
    } gcta_cmd_t;

    typedef struct packed {
        logic dup;
        logic nearest;
        logic [TCW-1:0] track_total;
        logic [DCW-1:0] pending_total;
        logic [TCW-1:0] keep_total;
    } gcta_sts_t;

    function automatic logic [8:0] sq_dist(input logic [3:0] r1, input logic [3:0] c1,
                                           input logic [3:0] r2, input logic [3:0] c2);
        logic [3:0] dr;
        logic [3:0] dc;
        dr = (r1 > r2) ? r1 - r2 : r2 - r1;
        dc = (c1 > c2) ? c1 - c2 : c2 - c1;
        // squares need 8 bits each, the sum 9
        return {1'b0, 8'(dr) * 8'(dr)} + {1'b0, 8'(dc) * 8'(dc)};
    endfunction
endpackage
`default_nettype wire

@@ sv/gcta_datapath.sv @@
// Datapath: track and detection tables, distance unit, ageing and output register.
// Depends on gcta_pkg.
`default_nettype none
module gcta_datapath import gcta_pkg::*; (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire gcta_cmd_t      cmd,
    input  wire logic [TW-1:0]  idx_i,
    input  wire logic [DW-1:0]  idx_j,
    input  wire logic [DW-1:0]  idx_k,
    input  wire logic [3:0]     in_row,
    input  wire logic [3:0]     in_col,
    input  wire logic [6:0]     cap,
    output gcta_sts_t           sts,
    output logic [15:0]         o_ident,
    output logic [3:0]          o_row,
    output logic [3:0]          o_col,
    output logic [6:0]          o_life,
    output logic                o_seen,
    output logic                o_valid,
    output logic                o_drop
);
    logic [3:0]  trow_reg [MAX_TRACKS];
    logic [3:0]  tcol_reg [MAX_TRACKS];
    logic [3:0]  r0_reg   [MAX_TRACKS];
    logic [3:0]  c0_reg   [MAX_TRACKS];
    logic [6:0]  life_reg [MAX_TRACKS];
    logic [15:0] id_reg   [MAX_TRACKS];
    logic [MAX_TRACKS-1:0] found_reg;
    logic [3:0]  prow_reg [MAX_DETECTIONS];
    logic [3:0]  pcol_reg [MAX_DETECTIONS];
    logic [MAX_DETECTIONS-1:0] used_reg;
    logic [TCW-1:0] ttot_reg;
    logic [DCW-1:0] ptot_reg;
    logic [TCW-1:0] keep_reg;
    logic [15:0] idc_reg;
    logic        drop_reg;
    logic [8:0]  dk_reg;        // distance of track i to detection k
    logic        near_reg;
    logic        have_reg;
    logic [8:0]  best_reg;
    logic [TW-1:0] pos_reg;
    logic [3:0]  ri_reg, ci_reg;

    logic [8:0] d_ij;
    logic [8:0] d_ik;
    logic [7:0] life_inc;
    logic [6:0] life_new;

    assign d_ij = sq_dist(ri_reg, ci_reg, prow_reg[idx_j], pcol_reg[idx_j]);
    assign d_ik = sq_dist(ri_reg, ci_reg, prow_reg[idx_k], pcol_reg[idx_k]);
    assign life_inc = {1'b0, life_reg[idx_i]} + 8'd1;

    always_comb begin
        if (found_reg[idx_i]) begin
            life_new = (life_inc > {1'b0, cap}) ? cap : life_inc[6:0];
        end else begin
            life_new = (life_reg[idx_i] != 7'd0) ? life_reg[idx_i] - 7'd1 : 7'd0;
        end
    end

    assign sts.dup = (prow_reg[idx_k] == in_row) && (pcol_reg[idx_k] == in_col);
    assign sts.nearest = near_reg;
    assign sts.track_total = ttot_reg;
    assign sts.pending_total = ptot_reg;
    assign sts.keep_total = keep_reg;

    // table storage, no reset on payload
    always_ff @(posedge aclk) begin
        if (cmd.add_push) begin
            prow_reg[ptot_reg[DW-1:0]] <= in_row;
            pcol_reg[ptot_reg[DW-1:0]] <= in_col;
        end
        if (cmd.clr_frame) begin
            r0_reg <= trow_reg;
            c0_reg <= tcol_reg;
        end
        if (cmd.load_trk) begin
            ri_reg <= r0_reg[idx_i];
            ci_reg <= c0_reg[idx_i];
        end
        if (cmd.near_init) begin
            near_reg <= 1'b1;
            dk_reg   <= d_ik;
        end
        if (cmd.near_step && (dk_reg > d_ij)) begin
            near_reg <= 1'b0;
        end
        if (cmd.best_step && near_reg && !(have_reg && dk_reg >= best_reg)) begin
            have_reg <= 1'b1;
            best_reg <= dk_reg;
            pos_reg  <= idx_i;
        end
        if (cmd.best_init) begin
            have_reg <= 1'b0;
        end
        if (cmd.assign_k && have_reg && !found_reg[pos_reg]) begin
            trow_reg[pos_reg] <= prow_reg[idx_k];
            tcol_reg[pos_reg] <= pcol_reg[idx_k];
        end
        if (cmd.new_k && !used_reg[idx_k] && ttot_reg < TCW'(MAX_TRACKS)) begin
            trow_reg[ttot_reg[TW-1:0]] <= prow_reg[idx_k];
            tcol_reg[ttot_reg[TW-1:0]] <= pcol_reg[idx_k];
            life_reg[ttot_reg[TW-1:0]] <= 7'd1;
            id_reg[ttot_reg[TW-1:0]]   <= idc_reg;
        end
        // compaction: keep index never exceeds i
        if (cmd.age_i && life_new != 7'd0) begin
            trow_reg[keep_reg[TW-1:0]] <= trow_reg[idx_i];
            tcol_reg[keep_reg[TW-1:0]] <= tcol_reg[idx_i];
            life_reg[keep_reg[TW-1:0]] <= life_new;
            id_reg[keep_reg[TW-1:0]]   <= id_reg[idx_i];
        end
        if (cmd.emit_i) begin
            o_ident <= id_reg[idx_i];
            o_row   <= trow_reg[idx_i];
            o_col   <= tcol_reg[idx_i];
            o_life  <= life_reg[idx_i];
            o_seen  <= found_reg[idx_i];
            o_valid <= 1'b1;
            o_drop  <= drop_reg;
        end
        if (cmd.emit_empty) begin
            o_ident <= '0;
            o_row   <= '0;
            o_col   <= '0;
            o_life  <= '0;
            o_seen  <= 1'b0;
            o_valid <= 1'b0;
            o_drop  <= drop_reg;
        end
    end

    // counters and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttot_reg  <= '0;
            ptot_reg  <= '0;
            keep_reg  <= '0;
            idc_reg   <= '0;
            drop_reg  <= 1'b0;
            found_reg <= '0;
            used_reg  <= '0;
        end else begin
            if (cmd.add_push) begin
                ptot_reg <= ptot_reg + DCW'(1);
            end
            if (cmd.clr_frame) begin
                found_reg <= '0;
                used_reg  <= '0;
                drop_reg  <= 1'b0;
            end
            if (cmd.assign_k && have_reg && !found_reg[pos_reg]) begin
                found_reg[pos_reg] <= 1'b1;
                used_reg[idx_k]    <= 1'b1;
            end
            if (cmd.new_k && !used_reg[idx_k]) begin
                if (ttot_reg < TCW'(MAX_TRACKS)) begin
                    found_reg[ttot_reg[TW-1:0]] <= 1'b1;
                    ttot_reg <= ttot_reg + TCW'(1);
                    idc_reg  <= idc_reg + 16'd1;
                end else begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.pend_clr) begin
                ptot_reg <= '0;
            end
            if (cmd.age_init) begin
                keep_reg <= '0;
            end
            if (cmd.age_i && life_new != 7'd0) begin
                found_reg[keep_reg[TW-1:0]] <= found_reg[idx_i];
                keep_reg <= keep_reg + TCW'(1);
            end
            if (cmd.emit_empty || cmd.emit_i) begin
                ttot_reg <= keep_reg;
            end
        end
    end
endmodule
`default_nettype wire

@@ sv/gcta_ctrl.sv @@
// Controller: sequences add, association, new-track, ageing and emit phases.
// Depends on gcta_pkg.
`default_nettype none
module gcta_ctrl import gcta_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_command,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_last,
    input  wire gcta_sts_t     sts,
    output gcta_cmd_t          cmd,
    output logic [TW-1:0]      idx_i,
    output logic [DW-1:0]      idx_j,
    output logic [DW-1:0]      idx_k
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_KHEAD = 4'd3;
    localparam logic [3:0] S_LOAD  = 4'd4;
    localparam logic [3:0] S_NINIT = 4'd5;
    localparam logic [3:0] S_NEAR  = 4'd6;
    localparam logic [3:0] S_BEST  = 4'd7;
    localparam logic [3:0] S_ASGN  = 4'd8;
    localparam logic [3:0] S_NEW   = 4'd9;
    localparam logic [3:0] S_AGE   = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [TCW-1:0] i_reg, i_next;
    logic [DCW-1:0] j_reg, j_next;
    logic [DCW-1:0] k_reg, k_next;
    logic last_reg, last_next;

    assign idx_i = i_reg[TW-1:0];
    assign idx_j = j_reg[DW-1:0];
    assign idx_k = k_reg[DW-1:0];
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_last  = last_reg;

    always_comb begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        last_next = last_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                k_next = '0;
                if (s_valid) begin
                    state_next = (s_command == CMD_END) ? S_CLR : S_SCAN;
                end
            end
            // duplicate search over pending list
            S_SCAN: begin
                if (k_reg == sts.pending_total) begin
                    if (sts.pending_total < DCW'(MAX_DETECTIONS)) begin
                        cmd.add_push = 1'b1;
                    end
                    state_next = S_IDLE;
                end else if (sts.dup) begin
                    state_next = S_IDLE;
                end else begin
                    k_next = k_reg + DCW'(1);
                end
            end
            S_CLR: begin
                cmd.clr_frame = 1'b1;
                k_next = '0;
                state_next = S_KHEAD;
            end
            S_KHEAD: begin
                cmd.best_init = 1'b1;
                i_next = '0;
                state_next = (k_reg == sts.pending_total) ? S_NEW : S_LOAD;
                if (k_reg == sts.pending_total) k_next = '0;
            end
            S_LOAD: begin
                if (i_reg == sts.track_total) begin
                    state_next = S_ASGN;
                end else begin
                    cmd.load_trk = 1'b1;
                    state_next = S_NINIT;
                end
            end
            S_NINIT: begin
                cmd.near_init = 1'b1;
                j_next = '0;
                state_next = S_NEAR;
            end
            S_NEAR: begin
                if (j_reg == sts.pending_total) begin
                    state_next = S_BEST;
                end else begin
                    cmd.near_step = 1'b1;
                    j_next = j_reg + DCW'(1);
                end
            end
            S_BEST: begin
                cmd.best_step = 1'b1;
                i_next = i_reg + TCW'(1);
                state_next = S_LOAD;
            end
            S_ASGN: begin
                cmd.assign_k = 1'b1;
                k_next = k_reg + DCW'(1);
                state_next = S_KHEAD;
            end
            // one detection per cycle is checked; a free one becomes a new track if the table has room
            S_NEW: begin
                if (k_reg == sts.pending_total) begin
                    cmd.pend_clr = 1'b1;
                    cmd.age_init = 1'b1;
                    i_next = '0;
                    state_next = S_AGE;
                end else begin
                    cmd.new_k = 1'b1;
                    k_next = k_reg + DCW'(1);
                end
            end
            S_AGE: begin
                if (i_reg == sts.track_total) begin
                    i_next = '0;
                    state_next = S_EMIT;
                end else begin
                    cmd.age_i = 1'b1;
                    i_next = i_reg + TCW'(1);
                end
            end
            S_EMIT: begin
                if (sts.keep_total == '0) begin
                    cmd.emit_empty = 1'b1;
                    last_next = 1'b1;
                end else begin
                    cmd.emit_i = 1'b1;
                    last_next = (i_reg + TCW'(1) == sts.keep_total);
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    if (last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        i_next = i_reg + TCW'(1);
                        state_next = S_EMIT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            last_reg <= last_next;
        end
    end
endmodule
`default_nettype wire

@@ sv/grid_cell_track_associator.sv @@
// Top level of the grid cell track associator: controller, datapath, config register.
// Depends on gcta_pkg, gcta_ctrl, gcta_datapath.
//
// Add-detection requests run a serial duplicate search over the pending cells. An
// end-of-frame request runs a sequencer over two distance units: association
// (the nearest-detection check walks every pending cell per track), then new
// tracks, ageing, and one emitted track at a time, each held until the sink
// takes it. One request is in flight at a time; input is taken only when the block
// is idle.
`default_nettype none
module grid_cell_track_associator import gcta_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_lifespan_cap,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [3:0]  s_cell_row,
    input  wire logic [3:0]  s_cell_col,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_track_ident,
    output logic [3:0]       m_trk_row,
    output logic [3:0]       m_trk_col,
    output logic [6:0]       m_life_left,
    output logic             m_seen_now,
    output logic             m_item_valid,
    output logic             m_last_item,
    output logic             m_new_dropped
);
    gcta_cmd_t cmd;
    gcta_sts_t sts;
    logic [TW-1:0] idx_i;
    logic [DW-1:0] idx_j, idx_k;
    logic [6:0] cap_reg;
    logic [3:0] req_row_reg, req_col_reg;

    // lifespan cap register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_lifespan_cap;
        end
    end

    // hold the accepted cell while the request is processed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_row_reg <= s_cell_row;
            req_col_reg <= s_cell_col;
        end
    end

    gcta_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .m_valid(m_valid), .m_ready(m_ready), .m_last(m_last_item),
        .sts(sts), .cmd(cmd), .idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k)
    );

    gcta_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k),
        .in_row(req_row_reg), .in_col(req_col_reg), .cap(cap_reg), .sts(sts),
        .o_ident(m_track_ident), .o_row(m_trk_row), .o_col(m_trk_col),
        .o_life(m_life_left), .o_seen(m_seen_now), .o_valid(m_item_valid),
        .o_drop(m_new_dropped)
    );
endmodule
`default_nettype wire

@@ sv/gcta_checker.sv @@
// Port-level checker for the grid cell track associator, with its bind.
// Depends on gcta_pkg and the assertion macro header.
`default_nettype none
`include "grid_cell_track_associator_defines.svh"
module gcta_checker import gcta_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_item_valid,
    input wire logic        m_last_item,
    input wire logic [6:0]  m_life_left,
    input wire logic [15:0] m_track_ident
);
    // result stays until taken
    `GCTA_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_track_ident))
    // no input taken while a result is shown
    `GCTA_ASSERT_IMP(a_excl, aclk, aresetn, m_valid, !s_ready)
    // empty frame marker is always the last item
    `GCTA_ASSERT_IMP(a_empty, aclk, aresetn, m_valid && !m_item_valid, m_last_item)
    // a surviving track never shows zero life
    `GCTA_ASSERT_IMP(a_life, aclk, aresetn, m_valid && m_item_valid, m_life_left != 7'd0)
endmodule

bind grid_cell_track_associator gcta_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_item_valid(m_item_valid),
    .m_last_item(m_last_item), .m_life_left(m_life_left),
    .m_track_ident(m_track_ident)
);
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for grid_cell_track_associator: detections, frame ends, cap changes.
// Depends on gcta_pkg and the grid_cell_track_associator RTL.
`timescale 1ns / 1ps
module testbench;
    import gcta_pkg::*;

    typedef struct packed {
        logic       command;
        logic [3:0] row;
        logic [3:0] col;
    } det_req_t;

    typedef struct packed {
        logic [15:0] ident;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [6:0]  life;
        logic        seen;
        logic        item_valid;
        logic        last;
        logic        dropped;
    } track_rpt_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [6:0] cfg_lifespan_cap = 7'd0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_command = 1'b0;
    logic [3:0] s_cell_row = 4'd0;
    logic [3:0] s_cell_col = 4'd0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_track_ident;
    logic [3:0] m_trk_row, m_trk_col;
    logic [6:0] m_life_left;
    logic m_seen_now, m_item_valid, m_last_item, m_new_dropped;

    grid_cell_track_associator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_lifespan_cap(cfg_lifespan_cap),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_cell_row(s_cell_row), .s_cell_col(s_cell_col),
        .m_valid(m_valid), .m_ready(m_ready), .m_track_ident(m_track_ident),
        .m_trk_row(m_trk_row), .m_trk_col(m_trk_col), .m_life_left(m_life_left),
        .m_seen_now(m_seen_now), .m_item_valid(m_item_valid),
        .m_last_item(m_last_item), .m_new_dropped(m_new_dropped)
    );

    always #4 aclk = ~aclk;

    // predictor state
    logic [3:0]  trk_row_q[MAX_TRACKS];
    logic [3:0]  trk_col_q[MAX_TRACKS];
    logic [6:0]  trk_life_q[MAX_TRACKS];
    logic [15:0] trk_ident_q[MAX_TRACKS];
    int          trk_cnt;
    logic [3:0]  det_row_q[MAX_DETECTIONS];
    logic [3:0]  det_col_q[MAX_DETECTIONS];
    int          det_cnt;
    logic [15:0] next_ident;
    logic [6:0]  life_cap;

    det_req_t   pending_reqs[$];
    track_rpt_t expected_tracks[$];
    int  send_idle_pct, recv_idle_pct;
    int  hold_off_cycles;
    bit  gap_pause;
    int  stall_cnt;
    bit  failed;

    function automatic int cell_dist(logic [3:0] r1, logic [3:0] c1,
                                     logic [3:0] r2, logic [3:0] c2);
        int dr, dc;
        dr = int'(r1) - int'(r2);
        dc = int'(c1) - int'(c2);
        return dr * dr + dc * dc;
    endfunction

    // Model one accepted request and queue the track reports it produces.
    task automatic predict_tracks(det_req_t req);
        bit found[MAX_TRACKS];
        bit used[MAX_DETECTIONS];
        logic [3:0] r0[MAX_TRACKS];
        logic [3:0] c0[MAX_TRACKS];
        bit dropped, have, nearest;
        int best, pos, d, keep, life;
        track_rpt_t rpt;
        if (req.command == CMD_ADD) begin
            for (int k = 0; k < det_cnt; k++)
                if (det_row_q[k] == req.row && det_col_q[k] == req.col) return;
            if (det_cnt < MAX_DETECTIONS) begin
                det_row_q[det_cnt] = req.row;
                det_col_q[det_cnt] = req.col;
                det_cnt++;
            end
            return;
        end
        dropped = 0;
        for (int i = 0; i < MAX_TRACKS; i++) begin
            found[i] = 0;
            r0[i] = trk_row_q[i];
            c0[i] = trk_col_q[i];
        end
        for (int k = 0; k < MAX_DETECTIONS; k++) used[k] = 0;
        // association against start-of-frame positions
        for (int k = 0; k < det_cnt; k++) begin
            have = 0; best = 0; pos = 0;
            for (int i = 0; i < trk_cnt; i++) begin
                d = cell_dist(r0[i], c0[i], det_row_q[k], det_col_q[k]);
                if (have && d >= best) continue;
                nearest = 1;
                for (int j = 0; j < det_cnt; j++)
                    if (d > cell_dist(r0[i], c0[i], det_row_q[j], det_col_q[j]))
                        nearest = 0;
                if (nearest) begin
                    have = 1; best = d; pos = i;
                end
            end
            if (have && !found[pos]) begin
                trk_row_q[pos] = det_row_q[k];
                trk_col_q[pos] = det_col_q[k];
                found[pos] = 1;
                used[k] = 1;
            end
        end
        // new tracks for free detections
        for (int k = 0; k < det_cnt; k++) begin
            if (used[k]) continue;
            if (trk_cnt >= MAX_TRACKS) begin
                dropped = 1;
                continue;
            end
            trk_row_q[trk_cnt] = det_row_q[k];
            trk_col_q[trk_cnt] = det_col_q[k];
            trk_life_q[trk_cnt] = 7'd1;
            trk_ident_q[trk_cnt] = next_ident;
            next_ident++;
            found[trk_cnt] = 1;
            trk_cnt++;
        end
        det_cnt = 0;
        // ageing and compaction
        keep = 0;
        for (int i = 0; i < trk_cnt; i++) begin
            life = trk_life_q[i];
            if (found[i]) begin
                life++;
                if (life > life_cap) life = life_cap;
            end else if (life > 0) begin
                life--;
            end
            if (life > 0) begin
                trk_row_q[keep] = trk_row_q[i];
                trk_col_q[keep] = trk_col_q[i];
                trk_life_q[keep] = life[6:0];
                trk_ident_q[keep] = trk_ident_q[i];
                found[keep] = found[i];
                keep++;
            end
        end
        trk_cnt = keep;
        if (keep == 0) begin
            rpt = '0;
            rpt.last = 1'b1;
            rpt.dropped = dropped;
            expected_tracks.insert(expected_tracks.size(), rpt);
        end
        for (int i = 0; i < keep; i++) begin
            rpt.ident = trk_ident_q[i];
            rpt.row = trk_row_q[i];
            rpt.col = trk_col_q[i];
            rpt.life = trk_life_q[i];
            rpt.seen = found[i];
            rpt.item_valid = 1'b1;
            rpt.last = (i + 1 == keep);
            rpt.dropped = dropped;
            expected_tracks.insert(expected_tracks.size(), rpt);
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_tracks('{s_command, s_cell_row, s_cell_col});
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && !gap_pause &&
                        $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    {s_command, s_cell_row, s_cell_col} <= pending_reqs.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                track_rpt_t got, want;
                got = '{m_track_ident, m_trk_row, m_trk_col, m_life_left, m_seen_now,
                        m_item_valid, m_last_item, m_new_dropped};
                if (expected_tracks.size() == 0) begin
                    $display("%0t: unexpected track report %h", $time, got);
                    failed = 1;
                end else begin
                    want = expected_tracks.pop_front();
                    if (got.ident != want.ident)
                        $display("%0t: ident exp %0d got %0d", $time, want.ident, got.ident);
                    if (got.row != want.row)
                        $display("%0t: row exp %0d got %0d", $time, want.row, got.row);
                    if (got.col != want.col)
                        $display("%0t: col exp %0d got %0d", $time, want.col, got.col);
                    if (got.life != want.life)
                        $display("%0t: life exp %0d got %0d", $time, want.life, got.life);
                    if (got.seen != want.seen)
                        $display("%0t: seen exp %0d got %0d", $time, want.seen, got.seen);
                    if (got.item_valid != want.item_valid)
                        $display("%0t: item_valid exp %0d got %0d", $time,
                                 want.item_valid, got.item_valid);
                    if (got.last != want.last)
                        $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                    if (got.dropped != want.dropped)
                        $display("%0t: dropped exp %0d got %0d", $time,
                                 want.dropped, got.dropped);
                    if (got != want) failed = 1;
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > 20000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_cap(logic [6:0] cap);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_lifespan_cap <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        life_cap = cap;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_valid || expected_tracks.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic add_cell(logic [3:0] r, logic [3:0] c);
        det_req_t req;
        req = '{CMD_ADD, r, c};
        pending_reqs.insert(pending_reqs.size(), req);
    endtask

    task automatic end_frame();
        det_req_t req;
        req = '{CMD_END, 4'($urandom_range(15)), 4'($urandom_range(15))};
        pending_reqs.insert(pending_reqs.size(), req);
    endtask

    // one frame of mostly moving objects near the current tracks
    task automatic random_frame(int n);
        for (int i = 0; i < n; i++) begin
            if (trk_cnt > 0 && $urandom_range(3) != 0) begin
                int t;
                t = $urandom_range(trk_cnt - 1);
                add_cell(4'(int'(trk_row_q[t]) + int'($urandom_range(2)) - 1),
                         4'(int'(trk_col_q[t]) + int'($urandom_range(2)) - 1));
            end else begin
                add_cell(4'($urandom_range(15)), 4'($urandom_range(15)));
            end
        end
        end_frame();
    endtask

    initial begin
        int sent;
        failed = 0; trk_cnt = 0; det_cnt = 0; next_ident = 0; life_cap = CAP_RESET;
        send_idle_pct = 0; recv_idle_pct = 0; hold_off_cycles = 0; gap_pause = 0;
        stall_cnt = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty frame, corners, duplicate, full detection list, table full
        end_frame();
        add_cell(0, 0); add_cell(15, 15); add_cell(0, 0); add_cell(15, 0);
        end_frame();
        add_cell(1, 0); add_cell(14, 14); add_cell(0, 15);
        end_frame();
        for (int i = 0; i < 17; i++) add_cell(i[3:0], 4'(15 - i));
        end_frame();
        wait_drained();
        for (int i = 0; i < 16; i++) add_cell(i[3:0], i[3:0] ^ 4'h5);
        end_frame();
        wait_drained();

        // tracks dying under cap 1; cap 0 wipes matches
        write_cap(7'd0);
        add_cell(7, 7); add_cell(8, 8);
        end_frame();
        wait_drained();
        write_cap(7'd1);
        end_frame(); end_frame();
        wait_drained();
        write_cap(7'd127);

        // long receiver hold-off while requests keep coming
        hold_off_cycles = 3000;
        for (int f = 0; f < 4; f++) random_frame(4);
        wait_drained();

        // sender paused after queuing a frame, then released before draining
        gap_pause = 1;
        random_frame(3);
        repeat (20) @(posedge aclk);
        gap_pause = 0;
        wait_drained();

        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 28; recv_idle_pct = 79; write_cap(7'd3); end
                1: begin send_idle_pct = 79; recv_idle_pct = 28; write_cap(7'd127); end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; write_cap(7'd10); end
            endcase
            while (sent < (phase + 1) * 128) begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(17) : $urandom_range(5);
                random_frame(n);
                sent += n + 1;
            end
            wait_drained();
        end

        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
